[hw/rtl/i2cbe_pkg.sv]
// shared types and constants for the i2c master bit engine
`default_nettype none

package i2cbe_pkg;

   // tick counter and timing register widths
   localparam int CNT_W  = 16;
   localparam int CFG_W  = 16;
   localparam int CMP_W  = (CNT_W > CFG_W) ? CNT_W : CFG_W;
   localparam int BYTE_W = 8;
   localparam int BIT_W  = 3;

   // last bit of a byte
   localparam logic [BIT_W-1:0] BIT_LAST = 3'd7;

   // reset values of the timing registers
   localparam logic [CFG_W-1:0] HALF_RESET = 16'd100;
   localparam logic [CFG_W-1:0] STOP_RESET = 16'd150;

   // register index as decoded from the csr address
   localparam logic REG_HALF = 1'b0;
   localparam logic REG_STOP = 1'b1;

   // command opcodes on the request channel
   localparam logic [1:0] OP_START = 2'd0;
   localparam logic [1:0] OP_STOP  = 2'd1;
   localparam logic [1:0] OP_WRITE = 2'd2;
   localparam logic [1:0] OP_READ  = 2'd3;

   // queues between the parts hold two beats
   localparam logic [1:0] Q_FULL = 2'd2;

   typedef enum logic [3:0] {
      PH_IDLE     = 4'd0,
      PH_START_A  = 4'd1,
      PH_START_B  = 4'd2,
      PH_STOP_A   = 4'd3,
      PH_STOP_B   = 4'd4,
      PH_WR_HIGH  = 4'd5,
      PH_WR_LOW   = 4'd6,
      PH_RD_LOW   = 4'd7,
      PH_RD_HIGH1 = 4'd8,
      PH_RD_HIGH2 = 4'd9,
      PH_ACK_LOW  = 4'd10,
      PH_ACK_HIGH = 4'd11
   } phase_type;

   typedef enum logic [2:0] {
      CMD_NONE  = 3'd0,
      CMD_START = 3'd1,
      CMD_STOP  = 3'd2,
      CMD_WRITE = 3'd3,
      CMD_READ  = 3'd4
   } cmd_type;

   // classified tick as it travels from the front to the engine
   typedef struct packed {
      cmd_type            cmd;
      logic [BYTE_W-1:0]  tx_byte;
      logic               send_ack;
      logic               sda_in;
   } item_type;

   // one result beat
   typedef struct packed {
      logic               scl_level;
      logic               sda_level;
      logic               sda_drive;
      logic               busy_res;
      logic               rx_valid;
      logic [BYTE_W-1:0]  rx_byte;
   } result_type;

endpackage

`default_nettype wire

[hw/rtl/i2cbe_front.sv]
// front part: accepts request beats, decodes the command and queues them
`default_nettype none

module i2cbe_front
   import i2cbe_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   output logic                   full,
   input  wire logic              req_cmd_valid,
   input  wire logic [1:0]        req_opcode,
   input  wire logic [BYTE_W-1:0] req_tx_byte,
   input  wire logic              req_send_ack,
   input  wire logic              req_sda_in,
   output logic                   item_valid,
   output item_type               item,
   input  wire logic              item_take
);

   item_type   q_ff [2];
   item_type   entry_in;
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push, do_pop;

   // decode the offered command
   always_comb begin
      entry_in.tx_byte  = req_tx_byte;
      entry_in.send_ack = req_send_ack;
      entry_in.sda_in   = req_sda_in;
      if (!req_cmd_valid) begin
         entry_in.cmd = CMD_NONE;
      end else begin
         unique case (req_opcode)
            OP_START: entry_in.cmd = CMD_START;
            OP_STOP:  entry_in.cmd = CMD_STOP;
            OP_WRITE: entry_in.cmd = CMD_WRITE;
            OP_READ:  entry_in.cmd = CMD_READ;
            default:  entry_in.cmd = CMD_NONE;
         endcase
      end
   end

   // queue control
   assign full       = (count_ff == Q_FULL);
   assign item_valid = (count_ff != 2'd0);
   assign item       = q_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = item_take && item_valid;

   always_comb begin
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         q_ff[wr_ptr_ff] <= entry_in;
      end
   end

endmodule

`default_nettype wire

[hw/rtl/i2cbe_engine.sv]
// back part: bit timing state machine and result queue
`default_nettype none

module i2cbe_engine
   import i2cbe_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             item_valid,
   input  item_type              item,
   output logic                  item_take,
   input  wire logic [CFG_W-1:0] half_ticks,
   input  wire logic [CFG_W-1:0] stop_ticks,
   output logic                  empty,
   input  wire logic             pop,
   output result_type            head
);

   phase_type         phase_ff, phase_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in, cnt_next;
   logic [BIT_W-1:0]  bit_ff, bit_in;
   logic [BYTE_W-1:0] shift_ff, shift_in;
   logic              ack_ff, ack_in;
   logic              scl_ff, scl_in;
   logic              sda_ff, sda_in;
   logic              en_ff, en_in;
   logic              rx_valid, fire, done;
   logic [BYTE_W-1:0] rx_byte;
   logic [CFG_W-1:0]  len_sel, len_eff;
   result_type        res;

   result_type        q_ff [2];
   logic              wr_ptr_ff, rd_ptr_ff;
   logic [1:0]        count_ff, count_in;
   logic              do_pop;

   // step when a tick waits and the result queue has room
   assign fire      = item_valid && (count_ff != Q_FULL);
   assign item_take = fire;

   // phase length and end of phase
   always_comb begin
      len_sel  = (phase_ff == PH_STOP_A || phase_ff == PH_STOP_B) ? stop_ticks : half_ticks;
      len_eff  = (len_sel == '0) ? CFG_W'(1) : len_sel;
      cnt_next = cnt_ff + CNT_W'(1);
      done     = (CMP_W'(cnt_next) >= CMP_W'(len_eff)) || (cnt_next == '1);
   end

   // next state
   always_comb begin
      phase_in = phase_ff;
      unique case (phase_ff)
         PH_IDLE: begin
            unique case (item.cmd)
               CMD_START: phase_in = PH_START_A;
               CMD_STOP:  phase_in = PH_STOP_A;
               CMD_WRITE: phase_in = PH_WR_HIGH;
               CMD_READ:  phase_in = PH_RD_LOW;
               default:   phase_in = PH_IDLE;
            endcase
         end
         PH_START_A:  if (done) phase_in = PH_START_B;
         PH_START_B:  if (done) phase_in = PH_IDLE;
         PH_STOP_A:   if (done) phase_in = PH_STOP_B;
         PH_STOP_B:   if (done) phase_in = PH_IDLE;
         PH_WR_HIGH:  if (done) phase_in = PH_WR_LOW;
         PH_WR_LOW:   if (done) phase_in = (bit_ff == BIT_LAST) ? PH_IDLE : PH_WR_HIGH;
         PH_RD_LOW:   if (done) phase_in = PH_RD_HIGH1;
         PH_RD_HIGH1: if (done) phase_in = PH_RD_HIGH2;
         PH_RD_HIGH2: if (done) phase_in = (bit_ff == BIT_LAST) ? PH_ACK_LOW : PH_RD_LOW;
         PH_ACK_LOW:  if (done) phase_in = PH_ACK_HIGH;
         PH_ACK_HIGH: if (done) phase_in = PH_IDLE;
         default:     phase_in = PH_IDLE;
      endcase
   end

   // datapath and pin outputs
   always_comb begin
      cnt_in   = cnt_ff;
      bit_in   = bit_ff;
      shift_in = shift_ff;
      ack_in   = ack_ff;
      scl_in   = scl_ff;
      sda_in   = sda_ff;
      en_in    = en_ff;
      rx_valid = 1'b0;
      rx_byte  = '0;
      if (phase_ff != PH_IDLE) begin
         cnt_in = done ? '0 : cnt_next;
      end
      unique case (phase_ff)
         PH_IDLE: begin
            cnt_in = '0;
            unique case (item.cmd)
               CMD_START: begin
                  en_in  = 1'b1;
                  sda_in = 1'b1;
                  scl_in = 1'b1;
               end
               CMD_STOP: begin
                  en_in  = 1'b1;
                  sda_in = 1'b0;
                  scl_in = 1'b0;
               end
               CMD_WRITE: begin
                  en_in    = 1'b1;
                  bit_in   = '0;
                  sda_in   = item.tx_byte[BYTE_W-1];
                  shift_in = {item.tx_byte[BYTE_W-2:0], 1'b0};
                  scl_in   = 1'b1;
               end
               CMD_READ: begin
                  en_in    = 1'b0;
                  shift_in = '0;
                  bit_in   = '0;
                  ack_in   = item.send_ack;
                  scl_in   = 1'b0;
               end
               default: ;
            endcase
         end
         PH_START_A:  if (done) sda_in = 1'b0;
         PH_START_B:  if (done) scl_in = 1'b0;
         PH_STOP_A:   if (done) scl_in = 1'b1;
         PH_STOP_B:   if (done) sda_in = 1'b1;
         PH_WR_HIGH:  if (done) scl_in = 1'b0;
         PH_WR_LOW: begin
            if (done && bit_ff != BIT_LAST) begin
               bit_in   = bit_ff + BIT_W'(1);
               sda_in   = shift_ff[BYTE_W-1];
               shift_in = {shift_ff[BYTE_W-2:0], 1'b0};
               scl_in   = 1'b1;
            end
         end
         PH_RD_LOW:   if (done) scl_in = 1'b1;
         PH_RD_HIGH1: ;
         PH_RD_HIGH2: begin
            if (done) begin
               shift_in = {shift_ff[BYTE_W-2:0], item.sda_in};
               scl_in   = 1'b0;
               if (bit_ff == BIT_LAST) begin
                  en_in  = 1'b1;
                  sda_in = ~ack_ff;
               end else begin
                  bit_in = bit_ff + BIT_W'(1);
               end
            end
         end
         PH_ACK_LOW:  if (done) scl_in = 1'b1;
         PH_ACK_HIGH: begin
            if (done) begin
               scl_in   = 1'b0;
               rx_valid = 1'b1;
               rx_byte  = shift_ff;
            end
         end
         default: cnt_in = '0;
      endcase
   end

   // result of this tick
   always_comb begin
      res.scl_level = scl_in;
      res.sda_level = sda_in;
      res.sda_drive = en_in;
      res.busy_res  = (phase_in != PH_IDLE);
      res.rx_valid  = rx_valid;
      res.rx_byte   = rx_byte;
   end

   // engine state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         cnt_ff   <= '0;
         bit_ff   <= '0;
         shift_ff <= '0;
         ack_ff   <= 1'b0;
         scl_ff   <= 1'b1;
         sda_ff   <= 1'b1;
         en_ff    <= 1'b1;
      end else if (fire) begin
         phase_ff <= phase_in;
         cnt_ff   <= cnt_in;
         bit_ff   <= bit_in;
         shift_ff <= shift_in;
         ack_ff   <= ack_in;
         scl_ff   <= scl_in;
         sda_ff   <= sda_in;
         en_ff    <= en_in;
      end
   end

   // result queue
   assign empty    = (count_ff == 2'd0);
   assign head     = q_ff[rd_ptr_ff];
   assign do_pop   = pop && !empty;
   assign count_in = count_ff + {1'b0, fire} - {1'b0, do_pop};

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= fire ? ~wr_ptr_ff : wr_ptr_ff;
         rd_ptr_ff <= do_pop ? ~rd_ptr_ff : rd_ptr_ff;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         q_ff[wr_ptr_ff] <= res;
      end
   end

   // tick counter is cleared whenever the engine rests
   assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_IDLE |-> cnt_ff == '0)
      else $error("tick counter not cleared in idle");

   // sda is released only during the data bits of a read
   assert property (@(posedge clock) disable iff (reset)
      !en_ff |-> (phase_ff == PH_RD_LOW || phase_ff == PH_RD_HIGH1 ||
                  phase_ff == PH_RD_HIGH2))
      else $error("sda released outside a read");

   // a received byte is reported only when the ack clock ends
   assert property (@(posedge clock) disable iff (reset)
      fire && rx_valid |-> phase_ff == PH_ACK_HIGH && phase_in == PH_IDLE)
      else $error("rx_valid outside the end of a read");

   // received byte is zero unless flagged valid
   assert property (@(posedge clock) disable iff (reset)
      fire && !rx_valid |-> rx_byte == '0)
      else $error("stray received byte");

   // the engine never steps into a full result queue
   assert property (@(posedge clock) disable iff (reset)
      count_ff == Q_FULL && !do_pop |=> count_ff == Q_FULL)
      else $error("result queue overflow");

endmodule

`default_nettype wire

[hw/rtl/i2c_master_bit_engine_unit.sv]
// top level of the i2c master bit engine with its timing registers
//
//   channel   ports                     beat moves when
//   request   push/full, req_*          push && !full
//   result    empty/pop, rsp_*          pop && !empty
//   csr       psel/penable/pwrite/...   psel && penable && pwrite (pready tied high)
//
// one request beat (one timer tick) is taken every cycle while full is low;
// its result beat reaches the result ports after the tick is written into the
// front queue and then an engine step, taken when the result queue has room, writes it.
// reset is synchronous; timing registers come up at 100 and 150 ticks.
// full rises when the two-beat front queue is full; a stalled result side
// fills the two-beat result queue and then holds the engine.
`default_nettype none

module i2c_master_bit_engine_unit
   import i2cbe_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   // request channel
   input  wire logic              push,
   output logic                   full,
   input  wire logic              req_cmd_valid,
   input  wire logic [1:0]        req_opcode,
   input  wire logic [BYTE_W-1:0] req_tx_byte,
   input  wire logic              req_send_ack,
   input  wire logic              req_sda_in,
   // result channel
   output logic                   empty,
   input  wire logic              pop,
   output logic                   rsp_scl_level,
   output logic                   rsp_sda_level,
   output logic                   rsp_sda_drive,
   output logic                   rsp_busy_res,
   output logic                   rsp_rx_valid,
   output logic [BYTE_W-1:0]      rsp_rx_byte,
   // csr port
   input  wire logic              psel,
   input  wire logic              penable,
   input  wire logic              pwrite,
   input  wire logic [2:0]        paddr,
   input  wire logic [31:0]       pwdata,
   output logic [31:0]            prdata,
   output logic                   pready
);

   logic [CFG_W-1:0] half_ff, half_in;
   logic [CFG_W-1:0] stop_ff, stop_in;
   logic             csr_wr;
   logic             item_valid, item_take;
   item_type         item;
   result_type       head;

   // timing registers
   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite && pready;

   always_comb begin
      half_in = half_ff;
      stop_in = stop_ff;
      if (csr_wr) begin
         unique case (paddr[2])
            REG_HALF: half_in = pwdata[CFG_W-1:0];
            REG_STOP: stop_in = pwdata[CFG_W-1:0];
            default:  ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         half_ff <= HALF_RESET;
         stop_ff <= STOP_RESET;
      end else begin
         half_ff <= half_in;
         stop_ff <= stop_in;
      end
   end

   // register readback
   always_comb begin
      unique case (paddr[2])
         REG_HALF: prdata = 32'(half_ff);
         REG_STOP: prdata = 32'(stop_ff);
         default:  prdata = '0;
      endcase
   end

   i2cbe_front u_front (
      .clock         (clock),
      .reset         (reset),
      .push          (push),
      .full          (full),
      .req_cmd_valid (req_cmd_valid),
      .req_opcode    (req_opcode),
      .req_tx_byte   (req_tx_byte),
      .req_send_ack  (req_send_ack),
      .req_sda_in    (req_sda_in),
      .item_valid    (item_valid),
      .item          (item),
      .item_take     (item_take)
   );

   i2cbe_engine u_engine (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .item       (item),
      .item_take  (item_take),
      .half_ticks (half_ff),
      .stop_ticks (stop_ff),
      .empty      (empty),
      .pop        (pop),
      .head       (head)
   );

   // result fields
   assign rsp_scl_level = head.scl_level;
   assign rsp_sda_level = head.sda_level;
   assign rsp_sda_drive = head.sda_drive;
   assign rsp_busy_res  = head.busy_res;
   assign rsp_rx_valid  = head.rx_valid;
   assign rsp_rx_byte   = head.rx_byte;

endmodule

`default_nettype wire

[test/i2c_master_bit_engine_unit_tb.sv]
// self-checking testbench for the i2c master bit engine unit
`timescale 1ns / 1ps

module i2c_master_bit_engine_unit_tb;
   import i2cbe_pkg::*;

   localparam int HANG_LIMIT  = 4000;
   localparam int HOLD_CYCLES = 60;
   localparam int DRAIN_TAIL  = 20;

   // csr byte addresses
   localparam logic [2:0] ADDR_HALF = {REG_HALF, 2'b00};
   localparam logic [2:0] ADDR_STOP = {REG_STOP, 2'b00};

   // sda_in patterns for the ticks of one command
   localparam logic [1:0] SDA_LOW  = 2'd0;
   localparam logic [1:0] SDA_HIGH = 2'd1;
   localparam logic [1:0] SDA_RAND = 2'd2;

   // one timer tick as offered on the request channel
   typedef struct packed {
      logic              cmd_valid;
      logic [1:0]        opcode;
      logic [BYTE_W-1:0] tx_byte;
      logic              send_ack;
      logic              sda_in;
   } tick_beat_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              push = 1'b0;
   logic              full;
   logic              req_cmd_valid = 1'b0;
   logic [1:0]        req_opcode = OP_START;
   logic [BYTE_W-1:0] req_tx_byte = '0;
   logic              req_send_ack = 1'b0;
   logic              req_sda_in = 1'b1;
   logic              empty;
   logic              pop = 1'b0;
   logic              rsp_scl_level;
   logic              rsp_sda_level;
   logic              rsp_sda_drive;
   logic              rsp_busy_res;
   logic              rsp_rx_valid;
   logic [BYTE_W-1:0] rsp_rx_byte;
   logic              psel = 1'b0;
   logic              penable = 1'b0;
   logic              pwrite = 1'b0;
   logic [2:0]        paddr = '0;
   logic [31:0]       pwdata = '0;
   logic [31:0]       prdata;
   logic              pready;

   i2c_master_bit_engine_unit dut (.*);

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ticks waiting to be offered and pin states still to come back
   tick_beat_type pending_ticks[$];
   result_type    predicted_pins[$];
   tick_beat_type offered_tick;
   tick_beat_type next_tick;
   result_type    seen_pins;

   // idling knobs, set between phases
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int hold_request = 0;
   int hold_seen = 0;
   int hold_left = 0;

   int fail_count = 0;
   int n_queued = 0;
   int n_ticks = 0;
   int n_checked = 0;
   int n_bytes_read = 0;
   int n_cmds = 0;
   int idle_cycles = 0;

   // random phase settings: half period, stop length, sender idle, receiver stall
   int half_set[4]  = '{1, 1, 2, 1};
   int stop_set[4]  = '{1, 3, 1, 2};
   int idle_set[4]  = '{0, 50, 0, 31};
   int stall_set[4] = '{0, 0, 50, 31};

   // bus engine shadow state
   logic [15:0]       half_len;
   logic [15:0]       stop_len;
   phase_type         ph;
   logic [3:0]        bit_idx;
   logic [BYTE_W-1:0] shreg;
   logic [15:0]       tick_cnt;
   logic              ack_sel;
   logic              scl_q;
   logic              sda_q;
   logic              drv_q;

   function automatic void engine_reset();
      half_len = HALF_RESET;
      stop_len = STOP_RESET;
      ph = PH_IDLE;
      bit_idx = '0;
      shreg = '0;
      tick_cnt = '0;
      ack_sel = 1'b0;
      scl_q = 1'b1;
      sda_q = 1'b1;
      drv_q = 1'b1;
   endfunction

   function automatic void enter_phase(phase_type nxt);
      ph = nxt;
      tick_cnt = '0;
   endfunction

   // put the msb of the shift register on sda with scl high
   function automatic void shift_out_bit();
      sda_q = shreg[7];
      shreg = {shreg[6:0], 1'b0};
      scl_q = 1'b1;
      enter_phase(PH_WR_HIGH);
   endfunction

   // advance the engine by one tick and return the pins after it
   function automatic result_type bus_tick(tick_beat_type t);
      result_type  r;
      logic [15:0] len;
      r = '0;
      if (ph == PH_IDLE) begin
         if (t.cmd_valid) begin
            case (t.opcode)
               OP_START: begin
                  drv_q = 1'b1;
                  sda_q = 1'b1;
                  scl_q = 1'b1;
                  enter_phase(PH_START_A);
               end
               OP_STOP: begin
                  drv_q = 1'b1;
                  sda_q = 1'b0;
                  scl_q = 1'b0;
                  enter_phase(PH_STOP_A);
               end
               OP_WRITE: begin
                  drv_q = 1'b1;
                  shreg = t.tx_byte;
                  bit_idx = '0;
                  shift_out_bit();
               end
               default: begin
                  drv_q = 1'b0;
                  shreg = '0;
                  bit_idx = '0;
                  ack_sel = t.send_ack;
                  scl_q = 1'b0;
                  enter_phase(PH_RD_LOW);
               end
            endcase
         end
      end else begin
         len = (ph == PH_STOP_A || ph == PH_STOP_B) ? stop_len : half_len;
         if (len == 0) len = 16'd1;
         tick_cnt = tick_cnt + 16'd1;
         if (tick_cnt >= len || tick_cnt == 16'hFFFF) begin
            case (ph)
               PH_START_A: begin
                  sda_q = 1'b0;
                  enter_phase(PH_START_B);
               end
               PH_START_B: begin
                  scl_q = 1'b0;
                  enter_phase(PH_IDLE);
               end
               PH_STOP_A: begin
                  scl_q = 1'b1;
                  enter_phase(PH_STOP_B);
               end
               PH_STOP_B: begin
                  sda_q = 1'b1;
                  enter_phase(PH_IDLE);
               end
               PH_WR_HIGH: begin
                  scl_q = 1'b0;
                  enter_phase(PH_WR_LOW);
               end
               PH_WR_LOW: begin
                  if (bit_idx >= 4'(BIT_LAST)) begin
                     enter_phase(PH_IDLE);
                  end else begin
                     bit_idx = bit_idx + 4'd1;
                     shift_out_bit();
                  end
               end
               PH_RD_LOW: begin
                  scl_q = 1'b1;
                  enter_phase(PH_RD_HIGH1);
               end
               PH_RD_HIGH1: enter_phase(PH_RD_HIGH2);
               PH_RD_HIGH2: begin
                  // sample at the end of scl high
                  shreg = {shreg[6:0], t.sda_in};
                  scl_q = 1'b0;
                  if (bit_idx >= 4'(BIT_LAST)) begin
                     drv_q = 1'b1;
                     sda_q = ~ack_sel;
                     enter_phase(PH_ACK_LOW);
                  end else begin
                     bit_idx = bit_idx + 4'd1;
                     enter_phase(PH_RD_LOW);
                  end
               end
               PH_ACK_LOW: begin
                  scl_q = 1'b1;
                  enter_phase(PH_ACK_HIGH);
               end
               PH_ACK_HIGH: begin
                  scl_q = 1'b0;
                  r.rx_valid = 1'b1;
                  r.rx_byte = shreg;
                  enter_phase(PH_IDLE);
               end
               default: enter_phase(PH_IDLE);
            endcase
         end
      end
      r.scl_level = scl_q;
      r.sda_level = sda_q;
      r.sda_drive = drv_q;
      r.busy_res = (ph != PH_IDLE);
      return r;
   endfunction

   // ticks a command keeps the engine away from idle, plus the tick that carries the command
   function automatic int busy_ticks(logic [1:0] op);
      int h;
      int s;
      h = (half_len == 0) ? 1 : int'(half_len);
      s = (stop_len == 0) ? 1 : int'(stop_len);
      case (op)
         OP_START: return 2 * h + 1;
         OP_STOP:  return 2 * s + 1;
         OP_WRITE: return 16 * h + 1;
         default:  return 26 * h + 1;
      endcase
   endfunction

   function automatic int pick_slack();
      int r;
      r = $urandom_range(9);
      if (r < 6) return 0;
      if (r < 9) return $urandom_range(1, 3);
      return -1;
   endfunction

   function automatic void add_tick(logic cv, logic [1:0] op, logic [BYTE_W-1:0] tx,
                                    logic ack, logic sda);
      tick_beat_type t;
      t.cmd_valid = cv;
      t.opcode = op;
      t.tx_byte = tx;
      t.send_ack = ack;
      t.sda_in = sda;
      pending_ticks.push_back(t);
      n_queued++;
   endfunction

   function automatic logic sda_for(logic [1:0] pat);
      if (pat == SDA_LOW) return 1'b0;
      if (pat == SDA_HIGH) return 1'b1;
      return 1'($urandom_range(1));
   endfunction

   // idle ticks with random don't-care fields
   function automatic void add_gap(int n);
      repeat (n) begin
         add_tick(1'b0, 2'($urandom_range(3)), 8'($urandom_range(255)),
                  1'($urandom_range(1)), 1'($urandom_range(1)));
      end
   endfunction

   // a command, then filler ticks until the engine should be idle again;
   // now and then a command is offered while busy and must be ignored
   function automatic void add_cmd(logic [1:0] op, logic [BYTE_W-1:0] tx, logic ack,
                                   logic [1:0] pat, int slack);
      int span;
      span = busy_ticks(op);
      add_tick(1'b1, op, tx, ack, sda_for(pat));
      n_cmds++;
      for (int i = 1; i < span + slack; i++) begin
         if (i < span && $urandom_range(19) == 0)
            add_tick(1'b1, 2'($urandom_range(3)), 8'($urandom_range(255)),
                     1'($urandom_range(1)), sda_for(pat));
         else
            add_tick(1'b0, 2'($urandom_range(3)), 8'($urandom_range(255)),
                     1'($urandom_range(1)), sda_for(pat));
      end
   endfunction

   // mostly framed transfers, some stray commands and idle runs
   function automatic void random_traffic(int n);
      int stop_at;
      int k;
      stop_at = n_queued + n;
      while (n_queued < stop_at) begin
         if ($urandom_range(4) != 0) begin
            add_cmd(OP_START, 8'($urandom_range(255)), 1'($urandom_range(1)), SDA_RAND,
                    pick_slack());
            k = $urandom_range(1, 3);
            repeat (k) begin
               if ($urandom_range(1))
                  add_cmd(OP_WRITE, 8'($urandom_range(255)), 1'($urandom_range(1)),
                          SDA_RAND, pick_slack());
               else
                  add_cmd(OP_READ, 8'($urandom_range(255)), 1'($urandom_range(1)),
                          SDA_RAND, pick_slack());
            end
            add_cmd(OP_STOP, 8'($urandom_range(255)), 1'($urandom_range(1)), SDA_RAND,
                    pick_slack());
         end else if ($urandom_range(1)) begin
            add_cmd(2'($urandom_range(3)), 8'($urandom_range(255)), 1'($urandom_range(1)),
                    SDA_RAND, int'($urandom_range(6)) - 3);
         end else begin
            add_gap($urandom_range(1, 5));
         end
      end
   endfunction

   // wait until every tick is taken and every pin state has come back
   task automatic wait_idle();
      do @(negedge clock);
      while (pending_ticks.size() != 0 || push || predicted_pins.size() != 0);
      repeat (4) @(negedge clock);
   endtask

   task automatic csr_write(logic [2:0] addr, logic [31:0] data);
      @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= addr;
      pwdata <= data;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      if (addr == ADDR_HALF) half_len = data[15:0];
      else stop_len = data[15:0];
   endtask

   task automatic csr_read_check(logic [2:0] addr, logic [15:0] want);
      @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= addr;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      if (prdata !== {16'h0, want}) begin
         $error("csr readback at %0d: expected %0h, actual %0h", addr, want, prdata);
         fail_count++;
      end
      psel <= 1'b0;
      penable <= 1'b0;
   endtask

   function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, actual %0h", name, want, got);
         fail_count++;
      end
   endfunction

   // reset release
   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
   end

   // request driver: hold a beat until taken, idle at random between beats
   always @(posedge clock) begin
      if (reset) begin
         push <= 1'b0;
      end else begin
         if (push && !full) begin
            predicted_pins.push_back(bus_tick(offered_tick));
            n_ticks++;
         end
         if (!push || !full) begin
            if (pending_ticks.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               next_tick = pending_ticks.pop_front();
               offered_tick = next_tick;
               push <= 1'b1;
               req_cmd_valid <= next_tick.cmd_valid;
               req_opcode <= next_tick.opcode;
               req_tx_byte <= next_tick.tx_byte;
               req_send_ack <= next_tick.send_ack;
               req_sda_in <= next_tick.sda_in;
            end else begin
               push <= 1'b0;
            end
         end
      end
   end

   // result monitor: compare each beat, stall at random or for a long hold
   always @(posedge clock) begin
      if (reset) begin
         pop <= 1'b0;
      end else begin
         if (pop && !empty) begin
            if (predicted_pins.size() == 0) begin
               $error("result beat with nothing expected");
               fail_count++;
            end else begin
               seen_pins = predicted_pins.pop_front();
               check_field("scl_level", 8'(seen_pins.scl_level), 8'(rsp_scl_level));
               check_field("sda_level", 8'(seen_pins.sda_level), 8'(rsp_sda_level));
               check_field("sda_drive", 8'(seen_pins.sda_drive), 8'(rsp_sda_drive));
               check_field("busy_res", 8'(seen_pins.busy_res), 8'(rsp_busy_res));
               check_field("rx_valid", 8'(seen_pins.rx_valid), 8'(rsp_rx_valid));
               check_field("rx_byte", seen_pins.rx_byte, rsp_rx_byte);
               if (seen_pins.rx_valid) n_bytes_read++;
               n_checked++;
            end
         end
         if (hold_request != hold_seen) begin
            hold_seen = hold_request;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left != 0) begin
            hold_left--;
            pop <= 1'b0;
         end else begin
            pop <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   // watchdog on cycles with no beat moving
   always @(posedge clock) begin
      if (reset) begin
         idle_cycles = 0;
      end else begin
         if ((push && !full) || (pop && !empty)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= HANG_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
         end
      end
   end

   // stimulus sequence
   initial begin
      engine_reset();
      wait (!reset);
      @(negedge clock);

      // registers come up at their reset values
      csr_read_check(ADDR_HALF, HALF_RESET);
      csr_read_check(ADDR_STOP, STOP_RESET);

      // start condition at reset timing
      add_cmd(OP_START, 8'h00, 1'b0, SDA_RAND, 0);
      wait_idle();

      // shortest timing; upper data bits are not part of the register
      csr_write(ADDR_HALF, 32'h0000_0001);
      csr_write(ADDR_STOP, 32'hABCD_0001);
      csr_read_check(ADDR_STOP, 16'd1);
      @(negedge clock);

      // every command, byte extremes, ack and nack, sda both ways
      add_cmd(OP_START, 8'h00, 1'b0, SDA_HIGH, 0);
      add_cmd(OP_WRITE, 8'h00, 1'b0, SDA_LOW, 0);
      add_cmd(OP_WRITE, 8'hFF, 1'b1, SDA_HIGH, 0);
      add_cmd(OP_READ, 8'h00, 1'b1, SDA_HIGH, 0);
      add_cmd(OP_READ, 8'hFF, 1'b0, SDA_LOW, 0);
      add_cmd(OP_READ, 8'hA5, 1'b1, SDA_RAND, 0);
      // commands landing while busy
      add_cmd(OP_WRITE, 8'hA5, 1'b0, SDA_RAND, -2);
      add_cmd(OP_STOP, 8'h00, 1'b0, SDA_RAND, 0);
      wait_idle();

      // zero length registers count as one tick
      csr_write(ADDR_HALF, 32'h0);
      csr_write(ADDR_STOP, 32'h0);
      @(negedge clock);
      add_cmd(OP_START, 8'h00, 1'b0, SDA_RAND, 0);
      add_cmd(OP_WRITE, 8'h5A, 1'b0, SDA_RAND, 0);
      add_cmd(OP_READ, 8'h00, 1'b1, SDA_RAND, 0);
      add_cmd(OP_STOP, 8'h00, 1'b0, SDA_RAND, 0);
      wait_idle();

      // longest lengths, then shortened while a command is under way
      csr_write(ADDR_HALF, 32'h0000_FFFF);
      @(negedge clock);
      add_tick(1'b1, OP_WRITE, 8'hC3, 1'b0, 1'b0);
      add_gap(30);
      wait_idle();
      csr_write(ADDR_HALF, 32'h1);
      csr_write(ADDR_STOP, 32'h0000_FFFF);
      @(negedge clock);
      add_gap(20);
      add_tick(1'b1, OP_STOP, 8'h00, 1'b0, 1'b1);
      add_gap(30);
      wait_idle();
      csr_write(ADDR_STOP, 32'h2);
      @(negedge clock);
      add_gap(10);
      wait_idle();

      // random phases with different timing and idling
      for (int p = 0; p < 4; p++) begin
         csr_write(ADDR_HALF, 32'(half_set[p]));
         csr_write(ADDR_STOP, 32'(stop_set[p]));
         @(negedge clock);
         send_idle_pct = idle_set[p];
         recv_stall_pct = stall_set[p];
         random_traffic(30);
         // receiver holds off while ticks keep coming
         if (p == 0) hold_request++;
         wait_idle();
      end

      repeat (DRAIN_TAIL) @(negedge clock);
      if (predicted_pins.size() != 0) begin
         $error("%0d result beats never arrived", predicted_pins.size());
         fail_count++;
      end
      $display("run: %0d ticks with %0d commands offered, %0d result beats compared",
               n_ticks, n_cmds, n_checked);
      $display("run: %0d bytes read, timing from zero to 65535 ticks", n_bytes_read);
      if (fail_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
